// ----- hdl/htw_pkg.sv -----
// ============================================================================
// htw_pkg: shared types and constants of the two-wire sensor master
// Transfer payload structs and the command codes used by the sequencer.
// ============================================================================
package htw_pkg;

  localparam logic [15:0] HalfPeriodReset = 16'd40;
  localparam logic [7:0]  CmdTemp         = 8'h03;
  localparam logic [7:0]  CmdHumid        = 8'h05;
  localparam logic [7:0]  CmdMask         = 8'h1F;

  typedef struct packed {
    logic data_in;
    logic opcode;
    logic start_req;
  } in_item_t;

  typedef struct packed {
    logic [15:0] raw_value;
    logic        done_res;
    logic        busy_res;
    logic        data_out;
    logic        data_drive;
    logic        sck;
  } res_t;

endpackage

// ----- hdl/humidity_sensor_two_wire_master.sv -----
// ============================================================================
// humidity_sensor_two_wire_master: two-wire humidity sensor bus master
// Each input transfer is one bus tick; each tick yields one result transfer
// carrying the SCK and DATA line levels, busy, done and the raw measurement.
// The slave channel carries start_req, opcode and the sampled DATA level.
// The master channel carries the line levels after that tick, busy_res,
// done_res and raw_value, which is nonzero only on the done tick.
// A transfer passes an input register and the sequencer into a result
// register.
// Throughput is one transfer per cycle while the receiver does not stall;
// the sequencer state advances once per tick in a single pass.
// The half period register is written through cfg_we_i and cfg_wdata_i; the
// user writes it only while no transaction is running, which the block does not enforce; a value of zero acts as one.
// Reset empties both registers, returns the sequencer to idle with SCK low
// and DATA released, and loads a half period of 40 ticks.
// When the receiver stalls, the result register holds its transfer and the
// input side stops accepting once the input register is also full.
// ============================================================================
module humidity_sensor_two_wire_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: start_req, opcode, data_in, zero fill.
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: sck, data_drive, data_out, busy_res, done_res,
  // raw_value[15:0], zero fill.
  output logic [23:0] m_axis_tdata_o
);
  import htw_pkg::*;

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     out_room;
  logic     step;
  res_t     step_res;
  res_t     out_res;

  assign in_item = in_item_t'(s_axis_tdata_i[2:0]);

  assign step = held_valid && out_room;

  htw_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (step),
    .item_o  (held_item)
  );

  htw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (held_item),
    .res_o       (step_res)
  );

  htw_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (step_res),
    .room_o  (out_room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {3'b000, out_res};

endmodule

// ----- hdl/htw_in_stage.sv -----
// ============================================================================
// htw_in_stage: input register
// Holds one accepted transfer until the sequencer takes it.
// ============================================================================
module htw_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  htw_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              take_i,
  output htw_pkg::in_item_t item_o
);
  import htw_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- hdl/htw_seq.sv -----
// ============================================================================
// htw_seq: bus sequencer
// Advances the bus state by one tick per item and forms the line levels.
// ============================================================================
module htw_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              step_i,
  input  htw_pkg::in_item_t item_i,
  output htw_pkg::res_t     res_o
);
  import htw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_SEND,
    PH_ACK_WAIT,
    PH_ACK_CLK,
    PH_WAIT_HIGH,
    PH_WAIT_LOW,
    PH_READ,
    PH_MACK
  } phase_e;

  // Start sequence levels per slot; the top entry repeats the last slot.
  localparam logic [7:0] StartSck = 8'b0011_0110;
  localparam logic [7:0] StartDat = 8'b1110_0011;

  phase_e      phase_q, phase_d;
  logic [15:0] half_q;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [1:0]  byte_q, byte_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] recv_q, recv_d;

  logic [15:0] hp;
  logic [15:0] tick_inc;
  logic        slot_end;
  logic [15:0] tick_slot;
  logic [1:0]  byte_inc;
  logic [2:0]  start_idx;
  logic        done;
  logic [15:0] raw;

  assign hp        = (half_q == 16'd0) ? 16'd1 : half_q;
  assign tick_inc  = tick_q + 16'd1;
  assign slot_end  = (tick_inc >= hp);
  assign tick_slot = slot_end ? 16'd0 : tick_inc;
  assign byte_inc  = byte_q + 2'd1;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    cmd_d   = cmd_q;
    recv_d  = recv_q;
    done    = 1'b0;
    raw     = 16'd0;
    case (phase_q)
      PH_START: begin
        tick_d = tick_slot;
        if (slot_end) begin
          if (bit_q >= 4'd6) begin
            phase_d = PH_SEND;
            bit_d   = 4'd0;
          end else begin
            bit_d = bit_q + 4'd1;
          end
        end
      end
      PH_SEND: begin
        tick_d = tick_slot;
        if (slot_end) begin
          if (bit_q[0]) begin
            cmd_d = {cmd_q[6:0], 1'b0};
          end
          if (bit_q == 4'd15) begin
            phase_d = PH_ACK_WAIT;
            bit_d   = 4'd0;
          end else begin
            bit_d = bit_q + 4'd1;
          end
        end
      end
      PH_ACK_WAIT: begin
        if (!item_i.data_in) begin
          phase_d = PH_ACK_CLK;
          bit_d   = 4'd0;
          tick_d  = 16'd0;
        end
      end
      PH_ACK_CLK: begin
        tick_d = tick_slot;
        if (slot_end) begin
          phase_d = PH_WAIT_HIGH;
          bit_d   = 4'd0;
        end
      end
      PH_WAIT_HIGH: begin
        if (item_i.data_in) begin
          phase_d = PH_WAIT_LOW;
          bit_d   = 4'd0;
          tick_d  = 16'd0;
        end
      end
      PH_WAIT_LOW: begin
        if (!item_i.data_in) begin
          phase_d = PH_READ;
          bit_d   = 4'd0;
          tick_d  = 16'd0;
          byte_d  = 2'd0;
          recv_d  = 16'd0;
        end
      end
      PH_READ: begin
        tick_d = tick_slot;
        if (slot_end) begin
          if (bit_q[0] && (byte_q < 2'd2)) begin
            recv_d = {recv_q[14:0], item_i.data_in};
          end
          if (bit_q == 4'd15) begin
            phase_d = PH_MACK;
            bit_d   = 4'd0;
          end else begin
            bit_d = bit_q + 4'd1;
          end
        end
      end
      PH_MACK: begin
        tick_d = tick_slot;
        if (slot_end) begin
          if (bit_q >= 4'd1) begin
            bit_d = 4'd0;
            if (byte_inc == 2'd3) begin
              done    = 1'b1;
              raw     = recv_q;
              byte_d  = 2'd0;
              phase_d = PH_IDLE;
            end else begin
              byte_d  = byte_inc;
              phase_d = PH_READ;
            end
          end else begin
            bit_d = bit_q + 4'd1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (item_i.start_req) begin
          cmd_d   = (item_i.opcode ? CmdHumid : CmdTemp) & CmdMask;
          phase_d = PH_START;
          bit_d   = 4'd0;
          tick_d  = 16'd0;
        end
      end
    endcase
  end

  assign start_idx = (bit_d < 4'd7) ? bit_d[2:0] : 3'd6;

  always_comb begin
    res_o.sck        = 1'b0;
    res_o.data_drive = 1'b0;
    res_o.data_out   = 1'b1;
    case (phase_d)
      PH_START: begin
        res_o.sck        = StartSck[start_idx];
        res_o.data_out   = StartDat[start_idx];
        res_o.data_drive = 1'b1;
      end
      PH_SEND: begin
        res_o.sck        = bit_d[0];
        res_o.data_drive = 1'b1;
        res_o.data_out   = cmd_d[7];
      end
      PH_ACK_CLK: begin
        res_o.sck = 1'b1;
      end
      PH_READ: begin
        res_o.sck = bit_d[0];
      end
      PH_MACK: begin
        res_o.sck        = bit_d[0];
        res_o.data_drive = 1'b1;
        res_o.data_out   = 1'b0;
      end
      default: begin
        res_o.sck = 1'b0;
      end
    endcase
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.raw_value = raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HalfPeriodReset;
      phase_q <= PH_IDLE;
      tick_q  <= 16'd0;
      bit_q   <= 4'd0;
      byte_q  <= 2'd0;
      cmd_q   <= 8'd0;
      recv_q  <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        bit_q   <= bit_d;
        byte_q  <= byte_d;
        cmd_q   <= cmd_d;
        recv_q  <= recv_d;
      end
    end
  end

endmodule

// ----- hdl/htw_out_stage.sv -----
// ============================================================================
// htw_out_stage: result register
// Holds one result transfer until the receiver takes it.
// ============================================================================
module htw_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  htw_pkg::res_t res_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          ready_i,
  output htw_pkg::res_t res_o
);
  import htw_pkg::*;

  logic valid_q;
  res_t res_q;

  assign room_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
